// File: design/btc_pkg.sv
// Shared constants and controller/datapath handshake types for the
// block transposition cipher. No dependencies.
package btc_pkg;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 4;
  localparam int KEY_W      = 36;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_DIGITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

  localparam logic [LEN_W-1:0]  KEY_LEN_RST    = 4'd1;
  localparam logic [KEY_W-1:0]  KEY_DIGITS_RST = 36'h987654321;
  localparam logic              DIR_ENCRYPT    = 1'b0;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h20;

  // controller -> datapath
  typedef struct packed {
    logic take;   // input request accepted
    logic emit;   // load next result into output register
    logic clear;  // last result of block loaded, reset fill count
  } btc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_done;   // current input completes a block
    logic emit_last;  // emit index is at the last block position
    logic slot_free;  // output register can take a result
  } btc_stat_t;

endpackage

// File: design/btc_if.sv
// Valid/ready channel interfaces for the cipher's input and result streams.
// Depends on btc_pkg.
interface btc_in_if;
  logic                      valid;
  logic                      ready;
  logic [btc_pkg::CHAR_W-1:0] data_char;
  logic                      msg_end;

  modport source (output valid, output data_char, output msg_end, input ready);
  modport sink (input valid, input data_char, input msg_end, output ready);
endinterface

interface btc_out_if;
  logic                      valid;
  logic                      ready;
  logic [btc_pkg::CHAR_W-1:0] out_char;
  logic                      out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// File: design/btc_ctrl.sv
// Controller: collect/emit state machine for the cipher.
// Depends on btc_pkg command and status types.
module btc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  btc_pkg::btc_stat_t stat,
  output btc_pkg::btc_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EMIT    = 2'b10
  } btc_state_t;

  btc_state_t state_r, state_nxt;

  always_comb begin
    in_ready  = (state_r == ST_COLLECT);
    cmd.take  = in_ready && in_valid;
    cmd.emit  = (state_r == ST_EMIT) && stat.slot_free;
    cmd.clear = cmd.emit && stat.emit_last;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: begin
        if (cmd.take && stat.blk_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.clear) state_nxt = ST_COLLECT;
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_COLLECT;
    else        state_r <= state_nxt;
  end

endmodule

// File: design/btc_dp.sv
// Datapath: config registers, block buffer, key permutation lookup and
// output register. Depends on btc_pkg.
module btc_dp #(
  parameter int MAX_KEY = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [btc_pkg::CHAR_W-1:0]     data_char,
  input  logic                          msg_end,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [btc_pkg::CHAR_W-1:0]     out_char,
  output logic                          out_last,
  input  btc_pkg::btc_cmd_t              cmd,
  output btc_pkg::btc_stat_t             stat
);

  localparam int LW    = btc_pkg::LEN_W;
  localparam int IDX_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_KEY);

  function automatic logic [btc_pkg::CHAR_W-1:0] to_lower(
    input logic [btc_pkg::CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  logic [LW-1:0]              key_len_r;
  logic [btc_pkg::KEY_W-1:0]  key_digits_r;
  logic                       direction_r;
  logic [btc_pkg::CHAR_W-1:0] buf_r [MAX_KEY];
  logic [LW-1:0]              fill_r, fill_nxt;
  logic [LW-1:0]              pos_r, pos_nxt;
  logic                       last_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [btc_pkg::CHAR_W-1:0] out_char_r;
  logic                       out_last_r;

  logic [LW-1:0]              len_eff;
  logic [LW-1:0]              wr_idx;
  logic [LW-1:0]              wr_cnt;
  logic [LW-1:0]              src;       // 1-based source position, 0 = pad
  logic [LW-1:0]              pos_key;   // key entry at current output position
  logic [LW-1:0]              pos_p1;
  logic [LW-1:0]              rd_idx;
  logic [btc_pkg::CHAR_W-1:0] res_char;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r    <= btc_pkg::KEY_LEN_RST;
      key_digits_r <= btc_pkg::KEY_DIGITS_RST;
      direction_r  <= btc_pkg::DIR_ENCRYPT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        btc_pkg::REG_KEY_LEN:    key_len_r    <= cfg_wdata[LW-1:0];
        btc_pkg::REG_KEY_DIGITS: key_digits_r <= cfg_wdata[btc_pkg::KEY_W-1:0];
        btc_pkg::REG_DIRECTION:  direction_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamp block length to 1..MAX_KEY
  always_comb begin
    len_eff = key_len_r;
    if (len_eff == '0)     len_eff = LW'(1);
    if (len_eff > MAX_LEN) len_eff = MAX_LEN;
  end

  // write slot: stale partial block (length lowered) restarts at zero
  assign wr_idx = (fill_r >= len_eff) ? '0 : fill_r;
  assign wr_cnt = wr_idx + LW'(1);

  always_comb begin
    stat.blk_done  = (wr_cnt >= len_eff) || msg_end;
    stat.emit_last = (pos_r == len_eff - LW'(1));
    stat.slot_free = !out_valid_r || out_ready;
  end

  // permutation lookup for the current output position
  assign pos_p1 = pos_r + LW'(1);

  always_comb begin
    pos_key = '0;
    for (int i = 0; i < MAX_KEY; i++) begin
      if (pos_r == LW'(i)) pos_key = key_digits_r[4*i +: 4];
    end
  end

  always_comb begin
    src = '0;
    if (direction_r) begin
      // inverse key; later entries take priority
      for (int i = 0; i < MAX_KEY; i++) begin
        if (LW'(i) < len_eff && key_digits_r[4*i +: 4] == pos_p1) src = LW'(i + 1);
      end
    end else if (pos_key != '0 && pos_key <= len_eff) begin
      src = pos_key;
    end
  end

  assign rd_idx = src - LW'(1);

  always_comb begin
    res_char = btc_pkg::PAD_CHAR;
    if (src != '0 && src <= fill_r) res_char = to_lower(buf_r[rd_idx[IDX_W-1:0]]);
  end

  // block buffer (no reset, read only where written)
  always_ff @(posedge clk) begin
    if (cmd.take) buf_r[wr_idx[IDX_W-1:0]] <= data_char;
  end

  always_comb begin
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    if (cmd.take) begin
      fill_nxt = wr_cnt;
      pos_nxt  = '0;
    end
    if (cmd.emit) pos_nxt = pos_p1;
    if (cmd.clear) begin
      fill_nxt = '0;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pos_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) last_r <= msg_end;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= res_char;
      out_last_r <= last_r && stat.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// File: design/block_transposition_cipher.sv
// Top level of the columnar block transposition cipher.
// Depends on btc_pkg, btc_if, btc_ctrl and btc_dp.
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    data_char[7:0], msg_end
//   out_chan  out   valid/ready    out_char[7:0], out_last
//   cfg_*     in    cfg_wr_en      cfg_index[1:0], cfg_wdata[35:0]
//
// A request that does not complete a block is taken without any emission.
// A request that completes a block (full, or msg_end) is followed by
// one emission per block position (the clamped key length), one result per
// cycle from the output register; input ready is low during emission.
// Output stalls hold the emission counter in place.
// rst_n is synchronous, active low: registers return to key_len 1,
// identity key, encrypt, empty block. The block buffer itself is not reset.
module block_transposition_cipher #(
  parameter int MAX_KEY = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  btc_in_if.sink                        in_chan,
  btc_out_if.source                     out_chan,
  input  logic                          cfg_wr_en,
  input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  btc_pkg::btc_cmd_t  cmd;
  btc_pkg::btc_stat_t stat;
  logic               in_ready;
  logic               out_valid;
  logic [btc_pkg::CHAR_W-1:0] out_char;
  logic               out_last;

  // collect/emit sequencing
  btc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // buffer, key lookup, output register
  btc_dp #(
    .MAX_KEY (MAX_KEY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .data_char (in_chan.data_char),
    .msg_end   (in_chan.msg_end),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid;
  assign out_chan.out_char = out_char;
  assign out_chan.out_last = out_last;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for block_transposition_cipher: directed and random messages.
// Depends on btc_pkg, btc_if and the cipher RTL.
module tb;

  localparam int MAX_KEY     = 9;
  localparam int QUIET_LIMIT = 1000;  // cycles with no request, result or write
  localparam int SETTLE      = 2 * MAX_KEY + 4;
  localparam int ITEMS       = 460;
  localparam logic [btc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index

  typedef struct packed {
    logic [btc_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } cipher_out_t;

  // Mirror of the cipher: holds its own block buffer, fill count and
  // register copy, and queues the bytes each accepted request releases.
  class columnar_cipher;
    logic [btc_pkg::CHAR_W-1:0] held [MAX_KEY];
    int unsigned                fill;
    logic [btc_pkg::LEN_W-1:0]  klen;
    logic [btc_pkg::KEY_W-1:0]  kdig;
    logic                       dir;
    cipher_out_t                due[$];
    int                         errors;

    function new();
      klen   = btc_pkg::KEY_LEN_RST;
      kdig   = btc_pkg::KEY_DIGITS_RST;
      dir    = btc_pkg::DIR_ENCRYPT;
      fill   = 0;
      errors = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function void write_reg(logic [btc_pkg::CFG_IDX_W-1:0]  idx,
                            logic [btc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        btc_pkg::REG_KEY_LEN:    klen = val[btc_pkg::LEN_W-1:0];
        btc_pkg::REG_KEY_DIGITS: kdig = val[btc_pkg::KEY_W-1:0];
        btc_pkg::REG_DIRECTION:  dir  = val[0];
        default: ;
      endcase
    endfunction

    function void take_char(logic [btc_pkg::CHAR_W-1:0] c, logic fin);
      int unsigned len;
      int unsigned e;
      int unsigned p;
      int unsigned src[MAX_KEY];
      cipher_out_t r;
      len = klen;
      if (len < 1) len = 1;
      if (len > MAX_KEY) len = MAX_KEY;
      // length lowered under a partial block: drop it
      if (fill >= len) fill = 0;
      held[fill] = c;
      fill++;
      if (fill < len && !fin) return;
      // src[j]: 1-based block position for output j, 0 = pad
      for (int j = 0; j < MAX_KEY; j++) src[j] = 0;
      for (int j = 0; j < len; j++) begin
        e = kdig[4*j +: 4];
        if (dir != btc_pkg::DIR_ENCRYPT) begin
          if (e >= 1 && e <= len) src[e-1] = j + 1;
        end else begin
          src[j] = (e >= 1 && e <= len) ? e : 0;
        end
      end
      for (int j = 0; j < len; j++) begin
        p = src[j];
        r.ch = btc_pkg::PAD_CHAR;
        if (p >= 1 && p <= fill) begin
          r.ch = held[p-1];
          if (r.ch >= 8'h41 && r.ch <= 8'h5A) r.ch = r.ch + 8'h20;
        end
        r.last = fin && (j + 1 == len);
        due.push_back(r);
      end
      fill = 0;
    endfunction

    function void compare_out(logic [btc_pkg::CHAR_W-1:0] ch, logic lst);
      cipher_out_t x;
      if (due.size() == 0) begin
        $error("out_char: expected none, got 0x%02h (out_last %0b)", ch, lst);
        errors++;
        return;
      end
      x = due.pop_front();
      if (x.ch !== ch) begin
        $error("out_char: expected 0x%02h, got 0x%02h", x.ch, ch);
        errors++;
      end
      if (x.last !== lst) begin
        $error("out_last: expected %0b, got %0b", x.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                           cfg_wr_en;
  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  btc_in_if  in_chan();
  btc_out_if out_chan();

  block_transposition_cipher #(
    .MAX_KEY(MAX_KEY)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  columnar_cipher cipher = new();
  bit  calm = 0;   // when set, neither side idles
  int  sent = 0;
  int  quiet = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: ready changes on the falling edge, low ~17% of cycles.
  initial begin
    out_chan.ready = 0;
    forever begin
      @(negedge clk);
      out_chan.ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // Every accepted result goes against the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready)
      cipher.compare_out(out_chan.out_char, out_chan.out_last);
  end

  // Watchdog: any request, result or register write counts as progress.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_wr_en)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests toggle it only in a random idle gap.
  task automatic send_char(input logic [btc_pkg::CHAR_W-1:0] c, input logic fin);
    while (!calm && $urandom_range(99) < 17) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_char <= c;
    in_chan.msg_end   <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    cipher.take_char(c, fin);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid, drain every expected byte, then give a partial request
  // time to land before anything touches the registers.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (cipher.due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes all three registers back to back; spare also hits the unmapped index.
  task automatic setup_cipher(input logic [btc_pkg::CFG_DATA_W-1:0] len_w,
                              input logic [btc_pkg::CFG_DATA_W-1:0] key_w,
                              input logic [btc_pkg::CFG_DATA_W-1:0] dir_w,
                              input bit spare);
    logic [btc_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [btc_pkg::CFG_DATA_W-1:0] val [4];
    idx[0] = btc_pkg::REG_KEY_LEN;    val[0] = len_w;
    idx[1] = btc_pkg::REG_KEY_DIGITS; val[1] = key_w;
    idx[2] = btc_pkg::REG_DIRECTION;  val[2] = dir_w;
    idx[3] = REG_SPARE;               val[3] = {$urandom(), 4'($urandom())};
    for (int i = 0; i < (spare ? 4 : 3); i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(negedge clk);
      cipher.write_reg(idx[i], val[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // One random setting followed by a few messages. Keys are mostly true
  // permutations; the rest are raw nibbles (zeros, duplicates, out of range).
  task automatic random_phase();
    logic [3:0]                 lenw;
    logic [3:0]                 ent [MAX_KEY];
    logic [3:0]                 tmp;
    logic [btc_pkg::KEY_W-1:0]  kd;
    logic [btc_pkg::CHAR_W-1:0] c;
    int unsigned                eff, nmsg, mlen, r, k;
    bit                         open_end;
    r = $urandom_range(99);
    if (r < 8)       lenw = 4'd0;
    else if (r < 16) lenw = 4'd9;
    else if (r < 22) lenw = 4'($urandom_range(15, 10));
    else if (r < 30) lenw = 4'd1;
    else             lenw = 4'($urandom_range(9, 2));
    eff = (lenw == 0) ? 1 : (lenw > MAX_KEY) ? MAX_KEY : lenw;
    for (int j = 0; j < MAX_KEY; j++) ent[j] = 4'($urandom());
    if ($urandom_range(99) < 80) begin
      for (int j = 0; j < eff; j++) ent[j] = 4'(j + 1);
      for (int j = eff - 1; j > 0; j--) begin
        k = $urandom_range(j, 0);
        tmp = ent[j]; ent[j] = ent[k]; ent[k] = tmp;
      end
    end
    for (int j = 0; j < MAX_KEY; j++) kd[4*j +: 4] = ent[j];
    // upper bits of the narrow registers are don't-care; toggle them anyway
    setup_cipher({$urandom(), lenw}, kd, {$urandom(), 3'($urandom()), 1'($urandom())},
                 $urandom_range(99) < 20);
    nmsg = $urandom_range(4, 1);
    // leaving the last message open carries a partial block into the next
    // setting, which may shorten the block under it
    open_end = $urandom_range(99) < 25;
    for (int m = 0; m < nmsg; m++) begin
      mlen = ($urandom_range(99) < 20) ? eff : $urandom_range(3 * eff, 1);
      for (int i = 0; i < mlen; i++) begin
        r = $urandom_range(99);
        if (r < 50)      c = 8'h41 + 8'($urandom_range(25));
        else if (r < 70) c = 8'h61 + 8'($urandom_range(25));
        else             c = 8'($urandom_range(255));
        send_char(c, (i == mlen - 1) && !(m == nmsg - 1 && open_end));
      end
    end
  endtask

  initial begin
    int phase;
    in_chan.valid     = 1'b0;
    in_chan.data_char = '0;
    in_chan.msg_end   = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting (one-byte blocks, identity): letter boundaries and
    // byte extremes, last request closes the message.
    setup_cipher(36'd1, btc_pkg::KEY_DIGITS_RST, 36'd0, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h5A, 1'b0);
    send_char(8'h5B, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);

    // key 3,1,4,2: full block that is also the message end, then a
    // short final block padded with spaces
    wait_idle();
    setup_cipher(36'd4, 36'hFFFFF2413, 36'd0, 1'b0);
    send_char(8'h57, 1'b0);
    send_char(8'h78, 1'b0);
    send_char(8'h59, 1'b0);
    send_char(8'h7A, 1'b1);
    send_char(8'h51, 1'b0);
    send_char(8'h72, 1'b1);

    // key 2,2,0,7,1 encrypt: zero and too-large entries pad
    wait_idle();
    setup_cipher(36'd5, 36'h000017022, 36'd0, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h42, 1'b0);
    send_char(8'h43, 1'b1);

    // same key decrypt: duplicate entry overwrites, unnamed slots pad
    wait_idle();
    setup_cipher(36'd5, 36'h000017022, 36'd1, 1'b0);
    send_char(8'h4D, 1'b0);
    send_char(8'h4E, 1'b0);
    send_char(8'h4F, 1'b0);
    send_char(8'h50, 1'b0);
    send_char(8'h51, 1'b1);

    // block length 0 behaves as 1
    wait_idle();
    setup_cipher(36'd0, btc_pkg::KEY_DIGITS_RST, 36'd0, 1'b0);
    send_char(8'h61, 1'b0);

    // partial block of 3, then length cut to 2: partial block is dropped
    wait_idle();
    setup_cipher(36'd5, btc_pkg::KEY_DIGITS_RST, 36'd0, 1'b0);
    send_char(8'h31, 1'b0);
    send_char(8'h32, 1'b0);
    send_char(8'h33, 1'b0);
    wait_idle();
    setup_cipher(36'd2, btc_pkg::KEY_DIGITS_RST, 36'd0, 1'b0);
    send_char(8'h58, 1'b1);

    // Random settings and messages; a stretch of phases runs without idling.
    phase = 0;
    while (sent < ITEMS) begin
      wait_idle();
      calm = (phase >= 6 && phase < 10);
      random_phase();
      phase++;
    end
    calm = 0;

    wait_idle();
    if (cipher.errors == 0 && cipher.due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
design/btc_pkg.sv
design/btc_if.sv
design/btc_ctrl.sv
design/btc_dp.sv
design/block_transposition_cipher.sv
tb/tb.sv
